FILE: rtl/core/clh_pkg.sv
// Shared constants and types for the Collatz length histogram block.
package clh_pkg;

	localparam int HIST_BINS  = 1024;
	localparam int VALUE_BITS = 32;

	localparam int CMD_W   = 1;
	localparam int START_W = 32;
	localparam int IDX_W   = 10;
	localparam int SEQ_W   = 10;
	localparam int COUNT_W = 32;
	localparam int TRAJ_W  = 64;

	localparam int BIN_W = $clog2(HIST_BINS);
	// Length counter wide enough for both the output saturation and the top bin.
	localparam int LEN_W = (BIN_W > SEQ_W) ? BIN_W : SEQ_W;

	localparam logic [SEQ_W-1:0]  LEN_MAX  = '1;
	localparam logic [BIN_W-1:0]  BIN_TOP  = BIN_W'(HIST_BINS - 1);
	localparam logic [TRAJ_W-1:0] TRIPLE_LIMIT = 64'h5555_5555_5555_5554;
	localparam logic [START_W-1:0] VALUE_MASK =
		(VALUE_BITS >= START_W) ? '1 : START_W'((64'd1 << VALUE_BITS) - 64'd1);

	typedef enum logic [CMD_W-1:0] {
		CMD_COMPUTE = 1'b0,
		CMD_READ    = 1'b1
	} cmd_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_STEP  = 6'b000100,
		ST_FETCH = 6'b001000,
		ST_USE   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

FILE: rtl/core/clh_in_if.sv
// Request channel: command, start value and bin index.
interface clh_in_if
	import clh_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [START_W-1:0] start_value;
	logic [IDX_W-1:0]   bin_index;

	modport source (output valid, output command, output start_value, output bin_index,
		input ready);
	modport sink (input valid, input command, input start_value, input bin_index,
		output ready);
endinterface

FILE: rtl/core/clh_out_if.sv
// Response channel: sequence length, bin count and overflow flag.
interface clh_out_if
	import clh_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [SEQ_W-1:0]   seq_length;
	logic [COUNT_W-1:0] bin_count;
	logic               overflow;

	modport source (output valid, output seq_length, output bin_count, output overflow,
		input ready);
	modport sink (input valid, input seq_length, input bin_count, input overflow,
		output ready);
endinterface

FILE: rtl/core/clh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/collatz_length_histogram_top.sv
// Collatz sequence length calculator with a length histogram in RAM.
//
//   channel | dir | payload                              | handshake
//   req     | in  | command, start_value, bin_index      | valid/ready
//   rsp     | out | seq_length, bin_count, overflow      | valid/ready
//
// A compute item is taken, runs its Collatz steps in the shared step
// unit, then goes through final check, bin read, bin update and response load. A bin
// read skips the steps and the check; an abandoned trajectory goes straight to the load.
// After reset a clearing pass writes zero to every bin, with req.ready low.
// A finished result waits in the response register until taken; the load stalls while
// that register is full and not being taken, and the next item is taken once loaded.
module collatz_length_histogram_top
	import clh_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	clh_in_if.sink   req,
	clh_out_if.source rsp
);
	state_t              state_q;
	logic [BIN_W-1:0]    clr_q;
	logic [TRAJ_W-1:0]   value_q;
	logic [LEN_W-1:0]    len_q;
	logic                is_read_q;
	logic                idx_ok_q;
	logic [BIN_W-1:0]    addr_q;

	logic [SEQ_W-1:0]    res_len_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic                res_ovf_q;

	logic                out_valid_q;
	logic [SEQ_W-1:0]    out_len_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_ovf_q;

	logic                ram_we;
	logic [BIN_W-1:0]    ram_waddr;
	logic [COUNT_W-1:0]  ram_wdata;
	logic [COUNT_W-1:0]  ram_rdata;

	logic                accept;
	logic                load_out;
	logic [TRAJ_W-1:0]   triple;
	logic [SEQ_W-1:0]    len_sat;
	logic [BIN_W-1:0]    len_bin;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// Shared step unit: 3v+1 as (v << 1) + v + 1
	assign triple = {value_q[TRAJ_W-2:0], 1'b0} + value_q + TRAJ_W'(1);

	assign len_sat = (len_q >= LEN_W'(LEN_MAX)) ? LEN_MAX : SEQ_W'(len_q);
	assign len_bin = (len_q >= LEN_W'(BIN_TOP)) ? BIN_TOP : BIN_W'(len_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = ram_rdata + COUNT_W'(1);
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if ((state_q == ST_USE) && !is_read_q) begin
			ram_we = 1'b1;
		end
	end

	clh_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (HIST_BINS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BIN_W'(1);
					if (clr_q == BIN_TOP) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req.command == CMD_READ) ? ST_FETCH : ST_STEP;
					end
				end
				ST_STEP: begin
					if (value_q <= TRAJ_W'(1)) begin
						state_q <= ST_FETCH;
					end else if (value_q[0] && (value_q > TRIPLE_LIMIT)) begin
						state_q <= ST_DONE;
					end
				end
				ST_FETCH: state_q <= ST_USE;
				ST_USE:   state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					is_read_q <= (req.command == CMD_READ);
					value_q   <= TRAJ_W'(req.start_value & VALUE_MASK);
					len_q     <= LEN_W'(1);
					addr_q    <= BIN_W'(req.bin_index);
					idx_ok_q  <= (32'(req.bin_index) < 32'(HIST_BINS));
				end
			end
			ST_STEP: begin
				if (value_q <= TRAJ_W'(1)) begin
					addr_q <= len_bin;
				end else if (!value_q[0]) begin
					value_q <= value_q >> 1;
					if (len_q != '1) len_q <= len_q + LEN_W'(1);
				end else if (value_q > TRIPLE_LIMIT) begin
					// abandon: flag overflow, leave the histogram alone
					res_len_q   <= '0;
					res_count_q <= '0;
					res_ovf_q   <= 1'b1;
				end else begin
					value_q <= triple;
					if (len_q != '1) len_q <= len_q + LEN_W'(1);
				end
			end
			ST_USE: begin
				res_ovf_q <= 1'b0;
				if (is_read_q) begin
					res_len_q   <= '0;
					res_count_q <= idx_ok_q ? ram_rdata : '0;
				end else begin
					res_len_q   <= len_sat;
					res_count_q <= '0;
				end
			end
			default: ;
		endcase
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_len_q   <= res_len_q;
			out_count_q <= res_count_q;
			out_ovf_q   <= res_ovf_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.seq_length = out_len_q;
	assign rsp.bin_count  = out_count_q;
	assign rsp.overflow   = out_ovf_q;
endmodule
